@@ hdl/mixture_marginal_loglik_softmax_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the mixture posterior block
// Each macro expands to a concurrent assertion clocked on clk, disabled while
// rst_n is low. Synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef MIXTURE_MARGINAL_LOGLIK_SOFTMAX_MACROS_SVH
`define MIXTURE_MARGINAL_LOGLIK_SOFTMAX_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define MMLS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmls assertion failed");
// Next-cycle implication
`define MMLS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmls assertion failed");
`else
`define MMLS_ASSERT_IMP(lbl, ante, cons)
`define MMLS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hdl/mmls_pkg.sv @@
// ----------------------------------------------------------------------------
// mmls_pkg
// Types and fixed constants of the mixture component posterior block.
// ----------------------------------------------------------------------------
`default_nettype none

package mmls_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_RESID_VAR  = 3'd0;
    localparam logic [2:0] REG_COMP_COUNT = 3'd1;
    localparam logic [2:0] REG_COMP0      = 3'd2;
    localparam logic [2:0] REG_COMP1      = 3'd3;
    localparam logic [2:0] REG_COMP2      = 3'd4;
    localparam logic [2:0] REG_COMP3      = 3'd5;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 56;

    // ln(2) in Q0.32 and log2(e) in Q2.30
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;

    // log2(2^31) in Q.24: reference point of the Q1.31 weight
    localparam logic [30:0] LOG_PI_REF = 31'd520093696;

    localparam logic signed [36:0] L_MAX = 37'sd2147483647;
    localparam logic signed [36:0] L_MIN = -37'sd2147483647;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_LNORM,
        ST_LSQ,
        ST_X,
        ST_XX,
        ST_CSTART,
        ST_BB,
        ST_LB,
        ST_LS,
        ST_T1,
        ST_NUM,
        ST_DEN,
        ST_T2,
        ST_LP,
        ST_LNPI,
        ST_LK,
        ST_ESTART,
        ST_EU,
        ST_ETERM,
        ST_EACC,
        ST_EFIN,
        ST_PSTART,
        ST_PQ,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

@@ hdl/mixture_marginal_loglik_softmax.sv @@
// ----------------------------------------------------------------------------
// mixture_marginal_loglik_softmax
// Per-marker mixture component log likelihoods and their softmax.
//
// One marker transfer in (dot product, squared norm, current effect) gives one
// result transfer per configured component, in index order, with tlast on the
// final one. Every step runs on a small sequencer around one shared datapath:
// a 192-bit shift-and-add multiplier, a bit-serial restoring divider, a
// normalise-and-square log2 unit and a 32x32 multiplier. An item takes two
// serial products up front, then per component the likelihood (dominated by
// the 192-bit division; the log2 normalise steps vary with the operand size),
// per weighted component the exponential (twelve Taylor divisions) and per
// result the normalising division plus any wait on m_tready. s_tready is high
// only while the block is idle. Configuration registers are to be written
// only while idle; the user must keep to this, the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mixture_marginal_loglik_softmax_macros.svh"

module mixture_marginal_loglik_softmax #(
    parameter int MAX_COMPONENTS = 4
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [2:0]                          cfg_index,
    input  wire logic [63:0]                         cfg_data,
    // marker statistics in
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    // [47:0] dot_product, [95:48] squared_norm, [127:96] current_effect
    input  wire logic [mmls_pkg::IN_TDATA_W-1:0]     s_tdata,
    // component results out
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    // [1:0] component_index, [33:2] loglik, [50:34] probability, zero pad
    output      logic [mmls_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output      logic                                m_tlast
);

    import mmls_pkg::*;

    localparam int CNT_W = $clog2(MAX_COMPONENTS + 1);
    localparam int IDX_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int TOT_W = 33 + $clog2(MAX_COMPONENTS);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [31:0] resid_reg;
    logic [2:0]  count_reg;
    logic [63:0] comp_word_reg [MAX_COMPONENTS];
    logic [2:0]  cfg_slot;

    assign cfg_slot = cfg_index - REG_COMP0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resid_reg <= 32'd16777216;
            count_reg <= 3'd1;
            for (int i = 0; i < MAX_COMPONENTS; i++)
            begin
                comp_word_reg[i] <= (i == 0) ? 64'd2147483648 : 64'd0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index) inside
                REG_RESID_VAR:  resid_reg <= cfg_data[31:0];
                REG_COMP_COUNT: count_reg <= cfg_data[2:0];
                REG_COMP0, REG_COMP1, REG_COMP2, REG_COMP3:
                begin
                    // drop writes to slots beyond the built component count
                    if (32'(cfg_slot) < MAX_COMPONENTS)
                    begin
                        comp_word_reg[cfg_slot[IDX_W-1:0]] <= cfg_data;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // latched marker
    logic [47:0]  nrm_reg, nrm_next;
    logic [47:0]  dmag_reg, dmag_next;
    logic         dneg_reg, dneg_next;
    logic         aneg_reg, aneg_next;
    logic [31:0]  se_reg, se_next;

    // shift-and-add multiplier
    logic [191:0] acc_reg, acc_next;
    logic [191:0] opa_reg, opa_next;
    logic [80:0]  opb_reg, opb_next;
    logic [6:0]   mcnt_reg, mcnt_next;

    // restoring divider
    logic [191:0] num_reg, num_next;
    logic [127:0] den_reg, den_next;
    logic [127:0] rem_reg, rem_next;
    logic [61:0]  quo_reg, quo_next;
    logic         sat_reg, sat_next;
    logic [7:0]   didx_reg, didx_next;

    // log2 unit
    logic [127:0] norm_reg, norm_next;
    logic [6:0]   lt_reg, lt_next;
    logic [31:0]  mant_reg, mant_next;
    logic [23:0]  frac_reg, frac_next;
    logic [4:0]   lsq_reg, lsq_next;

    // per-component likelihood terms
    logic [161:0] xx_reg, xx_next;
    logic [80:0]  bb_reg, bb_next;
    logic [30:0]  lb_reg, lb_next;
    logic [30:0]  diff_reg, diff_next;
    logic [23:0]  t1_reg, t1_next;
    logic [33:0]  t2_reg, t2_next;
    logic [30:0]  mag_reg, mag_next;
    logic         lpneg_reg, lpneg_next;
    logic signed [24:0] lnpi_reg, lnpi_next;
    logic signed [31:0] lk_reg [MAX_COMPONENTS];
    logic signed [31:0] lk_next [MAX_COMPONENTS];
    logic signed [31:0] mx_reg, mx_next;
    logic         any_reg, any_next;

    // exponential and normalisation
    logic [31:0]  ek_reg [MAX_COMPONENTS];
    logic [31:0]  ek_next [MAX_COMPONENTS];
    logic [TOT_W-1:0] total_reg, total_next;
    logic [17:0]  ip_reg, ip_next;
    logic [30:0]  f_reg, f_next;
    logic [30:0]  r_reg, r_next;
    logic [31:0]  term_reg, term_next;
    logic signed [33:0] sum_reg, sum_next;
    logic [3:0]   n_reg, n_next;
    logic [16:0]  pr_reg, pr_next;

    // ------------------------------------------------------------------
    // shared arithmetic
    // ------------------------------------------------------------------
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_p;
    logic [191:0] add_sum;
    logic [7:0]   qpos;
    logic [128:0] rem_sh, rem_sub;
    logic         rem_ge;
    logic [30:0]  log_val;
    logic [32:0]  sq_hi;
    logic [63:0]  rnd_p;

    assign mul_p   = mul_a * mul_b;
    assign add_sum = acc_reg + opa_reg;
    assign qpos    = didx_reg - 8'd1;
    assign rem_sh  = {rem_reg, num_reg[qpos]};
    assign rem_ge  = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign log_val = {lt_reg, frac_reg};
    assign sq_hi   = mul_p[63:31];
    assign rnd_p   = mul_p + 64'h0000_0080_0000_0000;

    // current component
    logic [IDX_W-1:0] kidx;
    logic [63:0]      cw;
    logic [31:0]      sk, pi;
    logic signed [31:0] lk_cur;
    logic [31:0]      ek_cur;
    logic [CNT_W-1:0] cnt_eff;

    assign kidx   = k_reg[IDX_W-1:0];
    assign cw     = comp_word_reg[kidx];
    assign sk     = cw[63:32];
    assign pi     = cw[31:0];
    assign lk_cur = lk_reg[kidx];
    assign ek_cur = ek_reg[kidx];
    assign cnt_eff = (32'(count_reg) > MAX_COMPONENTS) ? CNT_W'(MAX_COMPONENTS)
                                                       : CNT_W'(count_reg);

    // marker sign handling at the input
    logic [47:0] in_d, in_n;
    logic [31:0] in_a;
    assign in_d = s_tdata[47:0];
    assign in_n = s_tdata[95:48];
    assign in_a = s_tdata[127:96];

    // x = |d*2^24 + n*a|
    logic [79:0] x_p;
    logic [71:0] x_q;
    logic [80:0] x_val;
    assign x_p = acc_reg[79:0];
    assign x_q = {dmag_reg, 24'd0};
    always_comb
    begin
        if (dneg_reg == aneg_reg)
        begin
            x_val = {1'b0, x_p} + {9'd0, x_q};
        end
        else if ({8'd0, x_q} <= x_p)
        begin
            x_val = {1'b0, x_p - {8'd0, x_q}};
        end
        else
        begin
            x_val = {9'd0, x_q - x_p[71:0]};
        end
    end

    // likelihood combine: floor((t2 - t1)/2) + ln pi, clamped
    logic signed [35:0] d2;
    logic signed [36:0] lsum;
    logic signed [31:0] l_clamp;
    assign d2   = $signed({2'b00, t2_reg}) - $signed({12'd0, t1_reg});
    assign lsum = 37'(d2 >>> 1) + 37'(lnpi_reg);
    always_comb
    begin
        if (lsum > L_MAX)
        begin
            l_clamp = 32'(L_MAX);
        end
        else if (lsum < L_MIN)
        begin
            l_clamp = 32'(L_MIN);
        end
        else
        begin
            l_clamp = 32'(lsum);
        end
    end

    logic signed [32:0] vdiff;
    logic [32:0]        sum_pos;
    logic [32:0]        ek_sh;
    logic [23:0]        lv;
    assign vdiff   = 33'(mx_reg) - 33'(lk_cur);
    assign sum_pos = sum_reg[33] ? 33'd0 : sum_reg[32:0];
    assign ek_sh   = sum_pos >> ip_reg[4:0];
    assign lv      = rnd_p[63:40];

    // ------------------------------------------------------------------
    // next state and datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        nrm_next   = nrm_reg;
        dmag_next  = dmag_reg;
        dneg_next  = dneg_reg;
        aneg_next  = aneg_reg;
        se_next    = se_reg;
        acc_next   = acc_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        mcnt_next  = mcnt_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        sat_next   = sat_reg;
        didx_next  = didx_reg;
        norm_next  = norm_reg;
        lt_next    = lt_reg;
        mant_next  = mant_reg;
        frac_next  = frac_reg;
        lsq_next   = lsq_reg;
        xx_next    = xx_reg;
        bb_next    = bb_reg;
        lb_next    = lb_reg;
        diff_next  = diff_reg;
        t1_next    = t1_reg;
        t2_next    = t2_reg;
        mag_next   = mag_reg;
        lpneg_next = lpneg_reg;
        lnpi_next  = lnpi_reg;
        lk_next    = lk_reg;
        mx_next    = mx_reg;
        any_next   = any_reg;
        ek_next    = ek_reg;
        total_next = total_reg;
        ip_next    = ip_reg;
        f_next     = f_reg;
        r_next     = r_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        n_next     = n_reg;
        pr_next    = pr_reg;
        mul_a      = 32'd0;
        mul_b      = 32'd0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    nrm_next  = in_n;
                    dneg_next = in_d[47];
                    dmag_next = in_d[47] ? (~in_d + 48'd1) : in_d;
                    aneg_next = in_a[31];
                    se_next   = (resid_reg == 32'd0) ? 32'd1 : resid_reg;
                    cnt_next  = cnt_eff;
                    k_next    = '0;
                    any_next  = 1'b0;
                    mx_next   = 32'sd0;
                    // n * |a|
                    acc_next  = '0;
                    opa_next  = 192'(in_n);
                    opb_next  = 81'(in_a[31] ? (~in_a + 32'd1) : in_a);
                    mcnt_next = 7'd32;
                    ret_next  = ST_X;
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                if (opb_reg[0])
                begin
                    acc_next = add_sum;
                end
                opa_next  = {opa_reg[190:0], 1'b0};
                opb_next  = {1'b0, opb_reg[80:1]};
                mcnt_next = mcnt_reg - 7'd1;
                if (mcnt_reg == 7'd1)
                begin
                    state_next = ret_reg;
                end
            end

            ST_DIV:
            begin
                if (rem_ge)
                begin
                    rem_next = rem_sub[127:0];
                end
                else
                begin
                    rem_next = rem_sh[127:0];
                end
                // quotient bits at or above 2^62 only flag saturation
                quo_next  = {quo_reg[60:0], rem_ge & (qpos < 8'd62)};
                sat_next  = sat_reg | (rem_ge & (qpos >= 8'd62));
                didx_next = qpos;
                if (didx_reg == 8'd1)
                begin
                    state_next = ret_reg;
                end
            end

            ST_LNORM:
            begin
                if (norm_reg[127] || lt_reg == 7'd0)
                begin
                    mant_next  = norm_reg[127:96];
                    frac_next  = '0;
                    lsq_next   = 5'd24;
                    state_next = ST_LSQ;
                end
                else if (norm_reg[127:112] == 16'd0 && lt_reg >= 7'd16)
                begin
                    norm_next = {norm_reg[111:0], 16'd0};
                    lt_next   = lt_reg - 7'd16;
                end
                else
                begin
                    norm_next = {norm_reg[126:0], 1'b0};
                    lt_next   = lt_reg - 7'd1;
                end
            end

            ST_LSQ:
            begin
                mul_a = mant_reg;
                mul_b = mant_reg;
                if (sq_hi[32])
                begin
                    mant_next = sq_hi[32:1];
                    frac_next = {frac_reg[22:0], 1'b1};
                end
                else
                begin
                    mant_next = sq_hi[31:0];
                    frac_next = {frac_reg[22:0], 1'b0};
                end
                lsq_next = lsq_reg - 5'd1;
                if (lsq_reg == 5'd1)
                begin
                    state_next = ret_reg;
                end
            end

            ST_X:
            begin
                acc_next   = '0;
                opa_next   = 192'(x_val);
                opb_next   = x_val;
                mcnt_next  = 7'd81;
                ret_next   = ST_XX;
                state_next = ST_MUL;
            end

            ST_XX:
            begin
                xx_next    = acc_reg[161:0];
                k_next     = '0;
                state_next = ST_CSTART;
            end

            ST_CSTART:
            begin
                if (k_reg == cnt_reg)
                begin
                    k_next     = '0;
                    total_next = '0;
                    state_next = ST_ESTART;
                end
                else if (pi == 32'd0)
                begin
                    lk_next[kidx] = 32'sh8000_0000;
                    k_next        = k_reg + 1'b1;
                end
                else
                begin
                    // B = n*s_k + s_e*2^20
                    acc_next   = 192'({se_reg, 20'd0});
                    opa_next   = 192'(nrm_reg);
                    opb_next   = 81'(sk);
                    mcnt_next  = 7'd32;
                    ret_next   = ST_BB;
                    state_next = ST_MUL;
                end
            end

            ST_BB:
            begin
                bb_next    = acc_reg[80:0];
                norm_next  = 128'(acc_reg[80:0]);
                lt_next    = 7'd127;
                ret_next   = ST_LB;
                state_next = ST_LNORM;
            end

            ST_LB:
            begin
                lb_next    = log_val;
                norm_next  = 128'({se_reg, 20'd0});
                lt_next    = 7'd127;
                ret_next   = ST_LS;
                state_next = ST_LNORM;
            end

            ST_LS:
            begin
                diff_next  = (lb_reg > log_val) ? (lb_reg - log_val) : 31'd0;
                state_next = ST_T1;
            end

            ST_T1:
            begin
                mul_a      = {1'b0, diff_reg};
                mul_b      = LN2_Q32;
                t1_next    = lv;
                acc_next   = '0;
                opa_next   = 192'(xx_reg);
                opb_next   = 81'(sk);
                mcnt_next  = 7'd32;
                ret_next   = ST_NUM;
                state_next = ST_MUL;
            end

            ST_NUM:
            begin
                num_next   = acc_reg;
                acc_next   = '0;
                opa_next   = 192'(bb_reg);
                opb_next   = 81'(se_reg);
                mcnt_next  = 7'd32;
                ret_next   = ST_DEN;
                state_next = ST_MUL;
            end

            ST_DEN:
            begin
                den_next   = acc_reg[127:0];
                rem_next   = '0;
                quo_next   = '0;
                sat_next   = 1'b0;
                didx_next  = 8'd192;
                ret_next   = ST_T2;
                state_next = ST_DIV;
            end

            ST_T2:
            begin
                t2_next    = sat_reg ? {34{1'b1}} : quo_reg[61:28];
                norm_next  = 128'(pi);
                lt_next    = 7'd127;
                ret_next   = ST_LP;
                state_next = ST_LNORM;
            end

            ST_LP:
            begin
                lpneg_next = log_val < LOG_PI_REF;
                mag_next   = (log_val < LOG_PI_REF) ? (LOG_PI_REF - log_val)
                                                     : (log_val - LOG_PI_REF);
                state_next = ST_LNPI;
            end

            ST_LNPI:
            begin
                mul_a      = {1'b0, mag_reg};
                mul_b      = LN2_Q32;
                lnpi_next  = lpneg_reg ? -$signed({1'b0, lv}) : $signed({1'b0, lv});
                state_next = ST_LK;
            end

            ST_LK:
            begin
                lk_next[kidx] = l_clamp;
                if (!any_reg || l_clamp > mx_reg)
                begin
                    mx_next = l_clamp;
                end
                any_next   = 1'b1;
                k_next     = k_reg + 1'b1;
                state_next = ST_CSTART;
            end

            ST_ESTART:
            begin
                if (k_reg == cnt_reg)
                begin
                    k_next     = '0;
                    state_next = ST_PSTART;
                end
                else if (pi == 32'd0)
                begin
                    ek_next[kidx] = '0;
                    k_next        = k_reg + 1'b1;
                end
                else
                begin
                    // u = v * log2(e); integer part and Q.31 fraction
                    mul_a      = vdiff[31:0];
                    mul_b      = LOG2E_Q30;
                    ip_next    = mul_p[63:46];
                    f_next     = mul_p[45:15];
                    state_next = ST_EU;
                end
            end

            ST_EU:
            begin
                mul_a = {1'b0, f_reg};
                mul_b = LN2_Q32;
                if (ip_reg >= 18'd32)
                begin
                    ek_next[kidx] = '0;
                    k_next        = k_reg + 1'b1;
                    state_next    = ST_ESTART;
                end
                else
                begin
                    r_next     = mul_p[62:32];
                    term_next  = 32'h8000_0000;
                    sum_next   = 34'sh0_8000_0000;
                    n_next     = 4'd1;
                    state_next = ST_ETERM;
                end
            end

            ST_ETERM:
            begin
                // next Taylor term: (term*r >> 31) / n
                mul_a      = term_reg;
                mul_b      = {1'b0, r_reg};
                num_next   = 192'(mul_p[62:31]);
                den_next   = 128'(n_reg);
                rem_next   = '0;
                quo_next   = '0;
                sat_next   = 1'b0;
                didx_next  = 8'd32;
                ret_next   = ST_EACC;
                state_next = ST_DIV;
            end

            ST_EACC:
            begin
                term_next = quo_reg[31:0];
                if (n_reg[0])
                begin
                    sum_next = sum_reg - $signed({2'b00, quo_reg[31:0]});
                end
                else
                begin
                    sum_next = sum_reg + $signed({2'b00, quo_reg[31:0]});
                end
                if (n_reg == 4'd12)
                begin
                    state_next = ST_EFIN;
                end
                else
                begin
                    n_next     = n_reg + 4'd1;
                    state_next = ST_ETERM;
                end
            end

            ST_EFIN:
            begin
                ek_next[kidx] = ek_sh[31:0];
                total_next    = total_reg + TOT_W'(ek_sh[31:0]);
                k_next        = k_reg + 1'b1;
                state_next    = ST_ESTART;
            end

            ST_PSTART:
            begin
                if (k_reg == cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (total_reg == '0)
                begin
                    pr_next    = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    // round(e_k * 2^16 / total)
                    num_next   = 192'({ek_cur, 16'd0}) + 192'(total_reg >> 1);
                    den_next   = 128'(total_reg);
                    rem_next   = '0;
                    quo_next   = '0;
                    sat_next   = 1'b0;
                    didx_next  = 8'd64;
                    ret_next   = ST_PQ;
                    state_next = ST_DIV;
                end
            end

            ST_PQ:
            begin
                pr_next    = quo_reg[16:0];
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_PSTART;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
        end
    end

    // payload registers hold without reset
    always_ff @(posedge clk)
    begin
        nrm_reg   <= nrm_next;
        dmag_reg  <= dmag_next;
        dneg_reg  <= dneg_next;
        aneg_reg  <= aneg_next;
        se_reg    <= se_next;
        acc_reg   <= acc_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        mcnt_reg  <= mcnt_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        sat_reg   <= sat_next;
        didx_reg  <= didx_next;
        norm_reg  <= norm_next;
        lt_reg    <= lt_next;
        mant_reg  <= mant_next;
        frac_reg  <= frac_next;
        lsq_reg   <= lsq_next;
        xx_reg    <= xx_next;
        bb_reg    <= bb_next;
        lb_reg    <= lb_next;
        diff_reg  <= diff_next;
        t1_reg    <= t1_next;
        t2_reg    <= t2_next;
        mag_reg   <= mag_next;
        lpneg_reg <= lpneg_next;
        lnpi_reg  <= lnpi_next;
        lk_reg    <= lk_next;
        mx_reg    <= mx_next;
        any_reg   <= any_next;
        ek_reg    <= ek_next;
        total_reg <= total_next;
        ip_reg    <= ip_next;
        f_reg     <= f_next;
        r_reg     <= r_next;
        term_reg  <= term_next;
        sum_reg   <= sum_next;
        n_reg     <= n_next;
        pr_reg    <= pr_next;
    end

    // result transfer
    assign m_tdata = {5'd0, pr_reg, lk_cur, 2'(k_reg)};
    assign m_tlast = (k_reg + 1'b1) == cnt_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `MMLS_ASSERT_IMP(a_busy_excl, m_tvalid, !s_tready)
    `MMLS_ASSERT_IMP(a_div_rem, state_reg == ST_DIV, rem_reg < den_reg)
    `MMLS_ASSERT_IMP(a_k_bound, state_reg != ST_IDLE, k_reg <= cnt_reg)
    `MMLS_ASSERT_NXT(a_out_step, m_tvalid && m_tready, k_reg == $past(k_reg) + 1'b1)

endmodule

`default_nettype wire

@@ sim/tb_mixture_marginal_loglik_softmax.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mixture_marginal_loglik_softmax
// Self-checking bench for the mixture component posterior block.
//
// Marker statistics are queued by the stimulus process and presented by a
// clocked driver. Each accepted marker is run through a bit-true integer model
// of the log likelihoods and their softmax, which queues one expected result
// per component. A clocked monitor checks every result transfer against the
// oldest expectation. Configuration changes between phases, only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mixture_marginal_loglik_softmax;

    import mmls_pkg::*;

    typedef struct {
        logic [1:0]  idx;
        logic [31:0] loglik;
        logic [16:0] prob;
        logic        last;
    } comp_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = REG_RESID_VAR;
    logic [63:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic        m_tlast;

    // local copy of the register file
    logic [31:0] resid_var;
    logic [2:0]  comp_count;
    logic [63:0] comp_word [4];

    logic [IN_TDATA_W-1:0] marker_q [$];
    comp_result_t          posterior_q [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int markers_in    = 0;
    int results_out   = 0;
    int phase_count   = 0;
    bit long_hold_go  = 1'b0;
    bit long_hold_done = 1'b0;
    int hold_left     = 0;

    mixture_marginal_loglik_softmax #(.MAX_COMPONENTS(4)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bit-true model
    // ------------------------------------------------------------------------

    // log2 in Q.24: top bit position plus 24 fraction bits by repeated squaring
    function automatic logic [63:0] log2_q24(logic [191:0] a);
        int          top;
        int          p;
        logic [63:0] m;
        logic [63:0] fr;
        top = -1;
        m   = '0;
        fr  = '0;
        for (int i = 191; i >= 0; i--)
        begin
            if (top < 0 && a[i])
                top = i;
        end
        if (top < 0)
            return '0;
        for (int i = 0; i < 32; i++)
        begin
            p = top - i;
            m = (m << 1) | ((p >= 0) ? a[p] : 1'b0);
        end
        for (int i = 23; i >= 0; i--)
        begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                fr[i] = 1'b1;
            end
        end
        return (64'(top) << 24) | fr;
    endfunction

    // exp(-v) for v in Q.16, result Q.31
    function automatic logic [63:0] exp_neg_q31(logic [63:0] v);
        logic [63:0] u;
        logic [63:0] ip;
        logic [63:0] f31;
        logic [63:0] r;
        logic [63:0] term;
        longint      acc;
        u    = v * 64'(LOG2E_Q30);
        ip   = u >> 46;
        f31  = (u >> 15) & 64'h7FFF_FFFF;
        r    = (f31 * 64'(LN2_Q32)) >> 32;
        term = 64'h8000_0000;
        acc  = longint'(term);
        if (ip >= 32)
            return '0;
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * r) >> 31) / 64'(n);
            acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        return 64'(acc) >> ip;
    endfunction

    function automatic longint comp_loglik(logic [191:0] xx, logic [47:0] nrm,
                                           logic [31:0] se, logic [63:0] word);
        logic [191:0] sk;
        logic [191:0] s;
        logic [191:0] bb;
        logic [191:0] num;
        logic [191:0] den;
        logic [191:0] quo;
        logic [63:0]  lb;
        logic [63:0]  ls;
        logic [63:0]  diff;
        logic [63:0]  lp;
        logic [63:0]  mag;
        logic [127:0] wide;
        longint       t1;
        longint       t2;
        longint       lnpi;
        longint       d2;
        longint       l;
        sk   = 192'(word[63:32]);
        s    = 192'(se) << 20;
        bb   = 192'(nrm) * sk + s;
        lb   = log2_q24(bb);
        ls   = log2_q24(s);
        diff = (lb > ls) ? lb - ls : '0;
        wide = 128'(diff) * 128'(LN2_Q32) + (128'd1 << 39);
        t1   = longint'(wide >> 40);

        num = xx * sk;
        den = 192'(se) * bb;
        quo = num / den;
        // the quotient saturates just below 2^62
        if (quo >= (192'd1 << 62))
            quo = (192'd1 << 62) - 1;
        t2 = longint'(quo >> 28);

        lp   = log2_q24(192'(word[31:0]));
        mag  = (lp >= 64'(LOG_PI_REF)) ? lp - 64'(LOG_PI_REF) : 64'(LOG_PI_REF) - lp;
        wide = 128'(mag) * 128'(LN2_Q32) + (128'd1 << 39);
        lnpi = longint'(wide >> 40);
        if (lp < 64'(LOG_PI_REF))
            lnpi = -lnpi;

        d2 = t2 - t1;
        l  = (d2 >>> 1) + lnpi;
        if (l > 64'sd2147483647)
            l = 64'sd2147483647;
        if (l < -64'sd2147483647)
            l = -64'sd2147483647;
        return l;
    endfunction

    // Work out the posterior of one marker and queue its results
    function automatic void predict_posterior(logic [IN_TDATA_W-1:0] td);
        logic [47:0]  d;
        logic [47:0]  nrm;
        logic [31:0]  av;
        logic [47:0]  dmag;
        logic [31:0]  amag;
        logic [191:0] p;
        logic [191:0] q;
        logic [191:0] x;
        logic [31:0]  se;
        int           cnt;
        longint       lk [4];
        longint       mx;
        logic [63:0]  ek [4];
        logic [63:0]  total;
        bit           any;
        comp_result_t r;
        d    = td[47:0];
        nrm  = td[95:48];
        av   = td[127:96];
        dmag = d[47] ? -d : d;
        amag = av[31] ? -av : av;
        se   = (resid_var == 0) ? 32'd1 : resid_var;
        cnt  = (comp_count > 4) ? 4 : int'(comp_count);
        p    = 192'(nrm) * 192'(amag);
        q    = 192'(dmag) << 24;
        if (d[47] == av[31])
            x = p + q;
        else
            x = (p >= q) ? p - q : q - p;
        mx    = 0;
        any   = 1'b0;
        total = '0;
        for (int k = 0; k < cnt; k++)
        begin
            if (comp_word[k][31:0] == 0)
                lk[k] = -64'sd2147483648;
            else
            begin
                lk[k] = comp_loglik(x * x, nrm, se, comp_word[k]);
                if (!any || lk[k] > mx)
                    mx = lk[k];
                any = 1'b1;
            end
        end
        for (int k = 0; k < cnt; k++)
        begin
            ek[k] = (comp_word[k][31:0] != 0) ? exp_neg_q31(64'(mx - lk[k])) : '0;
            total += ek[k];
        end
        for (int k = 0; k < cnt; k++)
        begin
            r.idx    = 2'(k);
            r.loglik = lk[k][31:0];
            r.prob   = (total != 0) ? 17'((ek[k] * 65536 + total / 2) / total) : '0;
            r.last   = (k + 1 == cnt);
            posterior_q.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present queued markers, predicting each one on its transfer
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            predict_posterior(s_tdata);
            markers_in++;
        end
        if (!s_tvalid || s_tready)
        begin
            // hold tvalid low now and then
            if (rst_n && marker_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tdata  <= marker_q.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver back-pressure, with one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (long_hold_go && !long_hold_done)
        begin
            hold_left      <= 6000;
            long_hold_done <= 1'b1;
            m_tready       <= 1'b0;
        end
        else
            m_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        comp_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_out++;
            if (posterior_q.size() == 0)
            begin
                $display("%0t: unexpected result idx=%0d ll=%h prob=%0d last=%b", $time,
                         m_tdata[1:0], m_tdata[33:2], m_tdata[50:34], m_tlast);
                fail_count++;
            end
            else
            begin
                exp_r = posterior_q.pop_front();
                if (m_tdata[1:0] !== exp_r.idx)
                begin
                    $display("%0t: component_index expected %0d actual %0d",
                             $time, exp_r.idx, m_tdata[1:0]);
                    fail_count++;
                end
                if (m_tdata[33:2] !== exp_r.loglik)
                begin
                    $display("%0t: loglik expected %h actual %h",
                             $time, exp_r.loglik, m_tdata[33:2]);
                    fail_count++;
                end
                if (m_tdata[50:34] !== exp_r.prob)
                begin
                    $display("%0t: probability expected %0d actual %0d",
                             $time, exp_r.prob, m_tdata[50:34]);
                    fail_count++;
                end
                if (m_tlast !== exp_r.last)
                begin
                    $display("%0t: last_component expected %b actual %b",
                             $time, exp_r.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_RESID_VAR:  resid_var  = val[31:0];
            REG_COMP_COUNT: comp_count = val[2:0];
            REG_COMP0:      comp_word[0] = val;
            REG_COMP1:      comp_word[1] = val;
            REG_COMP2:      comp_word[2] = val;
            REG_COMP3:      comp_word[3] = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every marker is through and every result checked, then let
    // the block finish any marker that gave no result
    task automatic drain();
        while (marker_q.size() > 0 || s_tvalid || posterior_q.size() > 0)
            @(posedge clk);
        repeat (5000) @(posedge clk);
        phase_count++;
    endtask

    task automatic add_marker(logic [47:0] d, logic [47:0] n, logic [31:0] a);
        marker_q.push_back({a, n, d});
    endtask

    // value of up to w bits, often much narrower, so magnitudes spread widely
    function automatic logic [63:0] rnd_bits(int w);
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v >> (64 - w + $urandom_range(0, w - 1));
    endfunction

    function automatic logic [63:0] rnd_comp();
        logic [31:0] sk;
        logic [31:0] pi;
        case ($urandom_range(5))
            0:       sk = '0;
            1:       sk = 32'hFFFF_FFFF;
            default: sk = 32'(rnd_bits(32));
        endcase
        case ($urandom_range(6))
            0:       pi = '0;
            1:       pi = 32'h8000_0000;
            2:       pi = 32'hFFFF_FFFF;
            3:       pi = 32'd1;
            default: pi = 32'(rnd_bits(32));
        endcase
        return {sk, pi};
    endfunction

    initial
    begin
        logic [47:0] d;
        logic [31:0] a;
        resid_var  = 32'd16777216;
        comp_count = 3'd1;
        comp_word[0] = 64'h8000_0000;
        comp_word[1] = '0;
        comp_word[2] = '0;
        comp_word[3] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: one component, weight one, no component variance
        send_idle_pct = 14;
        recv_idle_pct = 78;
        add_marker(48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF);
        add_marker(48'h0, 48'h0, 32'h0);
        drain();

        // four components: zero variance, small, large, zero weight
        write_reg(REG_RESID_VAR, 64'd16777216);
        write_reg(REG_COMP_COUNT, 64'd4);
        write_reg(REG_COMP0, {32'd0, 32'h4000_0000});
        write_reg(REG_COMP1, {32'd167772, 32'h2000_0000});
        write_reg(REG_COMP2, {32'hFFFF_FFFF, 32'hFFFF_FFFF});
        write_reg(REG_COMP3, {32'h0100_0000, 32'd0});
        add_marker(48'h0, 48'h0, 32'h0);
        add_marker(48'h7FFF_FFFF_FFFF, 48'h0, 32'h0);
        add_marker(48'h8000_0000_0000, 48'h0, 32'h0);
        add_marker(48'h0, 48'hFFFF_FFFF_FFFF, 32'h0);
        add_marker(48'h0, 48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF);
        add_marker(48'h0, 48'hFFFF_FFFF_FFFF, 32'h8000_0000);
        add_marker(48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h8000_0000);
        add_marker(48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF, 32'h8000_0000);
        add_marker(48'h0010_0000, 48'h0010_0000, 32'h0100_0000);
        add_marker(48'hFFFF_FFF0_0000, 48'h0010_0000, 32'h0100_0000);
        add_marker(48'h1, 48'h1, 32'h1);
        add_marker(48'hFFFF_FFFF_FFFF, 48'h1, 32'hFFFF_FFFF);
        add_marker(48'h0640_0000, 48'h3E80_0000, 32'hFF00_0000);
        drain();

        // all weights zero, residual variance zero, count above the maximum
        write_reg(REG_RESID_VAR, 64'd0);
        write_reg(REG_COMP_COUNT, 64'd7);
        write_reg(REG_COMP0, {32'h0100_0000, 32'd0});
        write_reg(REG_COMP1, 64'd0);
        write_reg(REG_COMP2, {32'hFFFF_FFFF, 32'd0});
        write_reg(REG_COMP3, 64'd0);
        add_marker(48'h0123_4567_89AB, 48'h0000_1234_5678, 32'h0ABC_DEF0);
        add_marker(48'h0, 48'h0, 32'h0);
        drain();

        // no components: markers are taken but give nothing
        write_reg(REG_RESID_VAR, 64'hFFFF_FFFF);
        write_reg(REG_COMP_COUNT, 64'd0);
        add_marker(48'h0000_0010_0000, 48'h0000_0010_0000, 32'h0100_0000);
        add_marker(48'h0, 48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF);
        drain();

        // random phases, idling switched per third
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph < 4)
            begin
                send_idle_pct = 14;
                recv_idle_pct = 78;
            end
            else if (ph < 8)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 14;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(5))
                0:       write_reg(REG_RESID_VAR, 64'd1);
                1:       write_reg(REG_RESID_VAR, 64'hFFFF_FFFF);
                2:       write_reg(REG_RESID_VAR, 64'd16777216);
                default: write_reg(REG_RESID_VAR, 64'(rnd_bits(32)));
            endcase
            // mostly a working count, now and then zero or above the maximum
            if (ph == 5)
                write_reg(REG_COMP_COUNT, 64'($urandom_range(5, 7)));
            else if (ph == 10)
                write_reg(REG_COMP_COUNT, 64'd0);
            else
                write_reg(REG_COMP_COUNT, 64'($urandom_range(1, 4)));
            write_reg(REG_COMP0, rnd_comp());
            write_reg(REG_COMP1, rnd_comp());
            write_reg(REG_COMP2, rnd_comp());
            write_reg(REG_COMP3, rnd_comp());
            if (ph == 6)
            begin
                // stall the output for a long stretch while markers keep coming
                @(negedge clk);
                long_hold_go = 1'b1;
            end
            for (int i = 0; i < 40; i++)
            begin
                d = 48'(rnd_bits(47));
                if ($urandom_range(1))
                    d = -d;
                a = 32'(rnd_bits(31));
                if ($urandom_range(1))
                    a = -a;
                if ($urandom_range(9) == 0)
                    add_marker(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                               $urandom);
                else
                    add_marker(d, 48'(rnd_bits(48)), a);
            end
            drain();
        end

        $display("Covered %0d phases: %0d markers, %0d component results checked.",
                 phase_count, markers_in, results_out);
        $display("Register extremes, zero weights and variances, and a long output stall.");
        if (fail_count == 0 && posterior_q.size() == 0)
            $display("mixture_marginal_loglik_softmax regression: pass");
        else
            $display("mixture_marginal_loglik_softmax regression: fail");
        $finish;
    end

    // give up if the run hangs
    initial
    begin
        #80_000_000;
        $display("mixture_marginal_loglik_softmax regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
